// ----- rtl/trpg_pkg.sv -----
// ----------------------------------------------------------------------------
// trpg_pkg
// Types, constants and the palette of the tile row pixel generator.
// ----------------------------------------------------------------------------
package trpg_pkg;

  localparam int GFX_DEPTH      = 65536;
  localparam int GFX_AW         = $clog2(GFX_DEPTH);
  localparam int CELL_RAM_DEPTH = 256;
  localparam int CELL_AW        = $clog2(CELL_RAM_DEPTH);

  localparam logic [1:0] OP_WRITE_VRAM = 2'd0;
  localparam logic [1:0] OP_WRITE_CRAM = 2'd1;
  localparam logic [1:0] OP_WRITE_GFX  = 2'd2;
  localparam logic [1:0] OP_RENDER     = 2'd3;

  localparam logic [15:0] WIDE_OFF0_ODD  = 16'h0000;
  localparam logic [15:0] WIDE_OFF0_EVEN = 16'h4000;
  localparam logic [15:0] WIDE_OFF1_ODD  = 16'h8000;
  localparam logic [15:0] WIDE_OFF1_EVEN = 16'hc000;
  localparam logic [15:0] NARROW_OFF0_ODD  = 16'h0000;
  localparam logic [15:0] NARROW_OFF0_EVEN = 16'h2000;
  localparam logic [15:0] NARROW_OFF1_ODD  = 16'h4000;
  localparam logic [15:0] NARROW_OFF1_EVEN = 16'h6000;

  localparam logic [23:0] PALETTE [32] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h800000,
    24'h000000, 24'hf0f0f0, 24'hffff00, 24'h404040,
    24'h000000, 24'hffffff, 24'hff0000, 24'hffff00,
    24'h000000, 24'hffff00, 24'hd00000, 24'h800000,
    24'h000000, 24'hff0000, 24'hffff00, 24'h808000,
    24'h000000, 24'hff0000, 24'h404040, 24'hd0d0d0,
    24'h000000, 24'h0000ff, 24'h603040, 24'hffff00,
    24'h000000, 24'hff00ff, 24'h800080, 24'h400040
  };

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic [13:0] row_start;
    logic [3:0]  raster_row;
    logic [7:0]  cell_column;
    logic [8:0]  scan_line;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  line_out;
    logic [10:0] pixel_x;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
  } out_item_t;

endpackage

// ----- rtl/trpg_in_if.sv -----
// ----------------------------------------------------------------------------
// trpg_in_if
// Valid/ready channel that carries command transactions into the generator.
// ----------------------------------------------------------------------------
interface trpg_in_if;
  logic               valid;
  logic               ready;
  trpg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/trpg_out_if.sv -----
// ----------------------------------------------------------------------------
// trpg_out_if
// Valid/ready channel that carries pixel transactions out of the generator.
// ----------------------------------------------------------------------------
interface trpg_out_if;
  logic                valid;
  logic                ready;
  trpg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tile_row_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// tile_row_pixel_generator
// A render passes the cell RAM read, ROM read, serializer and output register.
// Throughput: one pixel per cycle while the pixel output is not stalled; the
// pixel serializer emits eight pixels per render. Write commands yield no pixels.
// Reset: a clearing pass over all 256 entries zeroes the video and color RAMs; no
// command is accepted until it ends. The graphics ROM is not cleared.
// ----------------------------------------------------------------------------
module tile_row_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  trpg_in_if.sink     cmd,
  trpg_out_if.source  pixel
);

  logic [7:0] video_ram [trpg_pkg::CELL_RAM_DEPTH];
  logic [7:0] color_ram [trpg_pkg::CELL_RAM_DEPTH];
  logic [7:0] gfx_rom [trpg_pkg::GFX_DEPTH];

  logic board_mode;
  logic clr_busy;
  logic [trpg_pkg::CELL_AW-1:0] clr_idx;

  logic cmd_acc;
  logic render_acc;
  logic [trpg_pkg::CELL_AW-1:0] cell_idx;
  logic [trpg_pkg::CELL_AW-1:0] cram_waddr;
  logic [trpg_pkg::CELL_AW-1:0] vram_waddr;
  logic [7:0] cram_wdata;
  logic [7:0] vram_wdata;
  logic cram_we;
  logic vram_we;

  // Stage 1: cell word read from the cell RAMs.
  logic       s1_valid;
  logic [7:0] vram_q;
  logic [7:0] cram_q;
  logic [7:0] s1_column;
  logic [3:0] s1_raster;
  logic [8:0] s1_line;

  // Stage 2: plane bytes read from the graphics ROM.
  logic       s2_valid;
  logic [7:0] plane0_q;
  logic [7:0] plane1_q;
  logic [2:0] s2_bank;
  logic [7:0] s2_column;
  logic [8:0] s2_line;

  // Serializer.
  logic       ser_valid;
  logic [2:0] ser_cnt;
  logic [7:0] ser_plane0;
  logic [7:0] ser_plane1;
  logic [2:0] ser_bank;
  logic [7:0] ser_column;
  logic [8:0] ser_line;

  logic                out_valid;
  trpg_pkg::out_item_t out_data;

  logic s1_adv;
  logic s2_adv;
  logic out_free;
  logic ser_last;

  logic [15:0] cell_word;
  logic [15:0] tile_addr;
  logic [15:0] off0;
  logic [15:0] off1;
  logic [15:0] plane0_addr;
  logic [15:0] plane1_addr;
  logic [4:0]  pen;
  logic [23:0] rgb;

  assign cmd.ready  = !clr_busy && (!s1_valid || !s2_valid);
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign render_acc = cmd_acc && (cmd.data.opcode == trpg_pkg::OP_RENDER);

  assign out_free = !out_valid || pixel.ready;
  assign ser_last = (ser_cnt == 3'd7);
  assign s2_adv   = !ser_valid || (out_free && ser_last);
  assign s1_adv   = !s2_valid || s2_adv;

  assign cell_idx = trpg_pkg::CELL_AW'(cmd.data.row_start[13:1] +
                                       13'(cmd.data.cell_column[7:1]));

  assign vram_we    = clr_busy || (cmd_acc && (cmd.data.opcode == trpg_pkg::OP_WRITE_VRAM));
  assign cram_we    = clr_busy || (cmd_acc && (cmd.data.opcode == trpg_pkg::OP_WRITE_CRAM));
  assign vram_waddr = clr_busy ? clr_idx : cmd.data.mem_address[trpg_pkg::CELL_AW-1:0];
  assign cram_waddr = vram_waddr;
  assign vram_wdata = clr_busy ? 8'h00 : cmd.data.write_data;
  assign cram_wdata = vram_wdata;

  always_ff @(posedge clk) begin
    if (vram_we) begin
      video_ram[vram_waddr] <= vram_wdata;
    end
    if (render_acc) begin
      vram_q <= video_ram[cell_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cram_we) begin
      color_ram[cram_waddr] <= cram_wdata;
    end
    if (render_acc) begin
      cram_q <= color_ram[cell_idx];
    end
  end

  assign cell_word = {cram_q, vram_q};

  always_comb begin
    if (board_mode) begin
      tile_addr = {3'b000, cell_word[8:0], s1_raster};
      off0 = s1_column[0] ? trpg_pkg::NARROW_OFF0_ODD : trpg_pkg::NARROW_OFF0_EVEN;
      off1 = s1_column[0] ? trpg_pkg::NARROW_OFF1_ODD : trpg_pkg::NARROW_OFF1_EVEN;
    end else begin
      tile_addr = {2'b00, cell_word[9:0], s1_raster};
      off0 = s1_column[0] ? trpg_pkg::WIDE_OFF0_ODD : trpg_pkg::WIDE_OFF0_EVEN;
      off1 = s1_column[0] ? trpg_pkg::WIDE_OFF1_ODD : trpg_pkg::WIDE_OFF1_EVEN;
    end
  end

  assign plane0_addr = tile_addr + off0;
  assign plane1_addr = tile_addr + off1;

  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.data.opcode == trpg_pkg::OP_WRITE_GFX)) begin
      gfx_rom[cmd.data.mem_address[trpg_pkg::GFX_AW-1:0]] <= cmd.data.write_data;
    end
    if (s1_valid && s1_adv) begin
      plane0_q <= gfx_rom[plane0_addr[trpg_pkg::GFX_AW-1:0]];
      plane1_q <= gfx_rom[plane1_addr[trpg_pkg::GFX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_mode <= 1'b0;
      clr_busy   <= 1'b1;
      clr_idx    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      ser_valid  <= 1'b0;
      ser_cnt    <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        board_mode <= cfg_wdata;
      end
      if (clr_busy) begin
        clr_idx <= clr_idx + trpg_pkg::CELL_AW'(1);
        if (clr_idx == trpg_pkg::CELL_AW'(trpg_pkg::CELL_RAM_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (render_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_valid && s2_adv) begin
        ser_valid <= 1'b1;
        ser_cnt   <= 3'd0;
      end else if (ser_valid && out_free) begin
        ser_cnt <= ser_cnt + 3'd1;
        if (ser_last) begin
          ser_valid <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid <= ser_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (render_acc) begin
      s1_column <= cmd.data.cell_column;
      s1_raster <= cmd.data.raster_row;
      s1_line   <= cmd.data.scan_line;
    end
    if (s1_valid && s1_adv) begin
      s2_bank   <= cell_word[14:12];
      s2_column <= s1_column;
      s2_line   <= s1_line;
    end
    if (s2_valid && s2_adv) begin
      ser_plane0 <= plane0_q;
      ser_plane1 <= plane1_q;
      ser_bank   <= s2_bank;
      ser_column <= s2_column;
      ser_line   <= s2_line;
    end else if (ser_valid && out_free) begin
      ser_plane0 <= {1'b0, ser_plane0[7:1]};
      ser_plane1 <= {1'b0, ser_plane1[7:1]};
    end
  end

  assign pen = {ser_bank, ser_plane0[0], ser_plane1[0]};
  assign rgb = trpg_pkg::PALETTE[pen];

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data.line_out   <= ser_line;
      out_data.pixel_x    <= {ser_column, ~ser_cnt};
      out_data.red        <= rgb[23:16];
      out_data.green      <= rgb[15:8];
      out_data.blue       <= rgb[7:0];
      out_data.last_pixel <= ser_last;
    end
  end

  assign pixel.valid = out_valid;
  assign pixel.data  = out_data;

endmodule
